### sv/assert_macros.svh
// Assertion macros for the clocked checkers of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define LIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define LIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### sv/lis_pkg.sv
package lis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W   = 32;
    localparam int LEN_W     = 7;
    localparam int M_TDATA_W = 40;

    // predecessor mark for the first element of a run
    localparam logic [CNT_W-1:0] NO_PRED = {CNT_W{1'b1}};

    typedef struct packed {
        logic [VALUE_W-1:0] element_value;
        logic [LEN_W-1:0]   lis_length;
        logic               last_of_run;
        logic               overflow;
    } lis_result_t;

    typedef struct packed {
        logic        load;
        lis_result_t res;
    } lis_load_t;

endpackage

### sv/lis_out_stage.sv
module lis_out_stage
    import lis_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lis_load_t            ld,
    output logic                 taken,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // element_value, lis_length, zero pad
    output logic                 m_tlast,
    output logic                 m_tuser    // overflow
);

    logic        valid_reg, valid_next;
    lis_result_t res_reg;

    assign taken = valid_reg & m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (ld.load) begin
            valid_next = 1'b1;
        end else if (taken) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.load) begin
            res_reg <= ld.res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - LEN_W){1'b0}},
                       res_reg.lis_length, res_reg.element_value};
    assign m_tlast  = res_reg.last_of_run;
    assign m_tuser  = res_reg.overflow;

endmodule

### sv/lis_with_reconstruction.sv
// Longest strictly increasing subsequence finder (patience method) with
// reconstruction. Send one signed 32-bit value per request on s_tdata and
// raise s_tlast on the final value of a sequence. Each accepted value costs
// a binary search over the sorted tail table, one compare per cycle in a
// single shared comparator, plus an update step: up to ceil(log2(T+1))
// compares where T is the current run-table length (six compares once 32
// or more tails are held; a search never sees more than 63). Only the
// first 64 values of a sequence are used; later ones are dropped and every
// result of that sequence carries m_tuser (overflow) = 1. After the final
// request the block walks the predecessor links backwards (one memory read
// pair per step) into a result buffer, then streams the L results in
// increasing order, one at a time, each held through any stall on m_tready.
// Each result carries the value, the length L and m_tlast on the last
// element. s_tready is low from the moment a value is accepted into the
// table until its update is done, and for the whole trace and output phase;
// afterwards the block is cleared for the next sequence.
module lis_with_reconstruction
    import lis_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,   // value
    input  logic                 s_tlast,   // final_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // element_value, lis_length, zero pad
    output logic                 m_tlast,   // last_of_run
    output logic                 m_tuser    // overflow
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SEARCH  = 4'd1;
    localparam logic [3:0] ST_WRITE   = 4'd2;
    localparam logic [3:0] ST_TR_INIT = 4'd3;
    localparam logic [3:0] ST_TR_CUR  = 4'd4;
    localparam logic [3:0] ST_TR_RD   = 4'd5;
    localparam logic [3:0] ST_TR_WR   = 4'd6;
    localparam logic [3:0] ST_EM_RD   = 4'd7;
    localparam logic [3:0] ST_EM_LD   = 4'd8;
    localparam logic [3:0] ST_EM_WAIT = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [VALUE_W-1:0] value_reg;
    logic               final_reg;
    logic [CNT_W-1:0]   tail_cnt_reg, tail_cnt_next;
    logic [CNT_W-1:0]   item_cnt_reg, item_cnt_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;

    // run tables and result buffer
    logic [VALUE_W-1:0] tail_mem   [MAX_ITEMS];
    logic [IDX_W-1:0]   src_mem    [MAX_ITEMS];
    logic [CNT_W-1:0]   pred_mem   [MAX_ITEMS];
    logic [VALUE_W-1:0] stored_mem [MAX_ITEMS];
    logic [VALUE_W-1:0] buf_mem    [MAX_ITEMS];

    logic [VALUE_W-1:0] tail_q, stored_q, buf_q;
    logic [IDX_W-1:0]   src_q;
    logic [CNT_W-1:0]   pred_q;

    logic               tail_re, src_re;
    logic [IDX_W-1:0]   tail_raddr, src_raddr;

    logic               s_accept;
    logic               less;
    logic [CNT_W-1:0]   srch_lo, srch_hi, srch_mid;
    logic [CNT_W-1:0]   last_slot;
    logic               at_last;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   pred_val;
    logic               taken;
    lis_load_t          out_ld;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;

    // shared comparator: one binary-search step per cycle
    assign less     = $signed(tail_q) < $signed(value_reg);
    assign srch_lo  = less ? ({1'b0, mid_reg} + CNT_W'(1)) : lo_reg;
    assign srch_hi  = less ? hi_reg : {1'b0, mid_reg};
    assign srch_mid = srch_lo + ((srch_hi - srch_lo) >> 1);

    assign pos       = lo_reg[IDX_W-1:0];
    assign idx       = item_cnt_reg[IDX_W-1:0];
    assign pred_val  = (lo_reg == '0) ? NO_PRED : {1'b0, src_q};
    assign last_slot = tail_cnt_reg - CNT_W'(1);
    assign at_last   = ({1'b0, slot_reg} == last_slot);

    always_comb begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        tail_cnt_next = tail_cnt_reg;
        item_cnt_next = item_cnt_reg;
        ovf_next      = ovf_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        tail_re       = 1'b0;
        tail_raddr    = mid_reg;
        src_re        = 1'b0;
        src_raddr     = last_slot[IDX_W-1:0];
        out_ld.load   = 1'b0;
        out_ld.res.element_value = buf_q;
        out_ld.res.lis_length    = tail_cnt_reg;
        out_ld.res.last_of_run   = at_last;
        out_ld.res.overflow      = ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (item_cnt_reg == CNT_W'(MAX_ITEMS)) begin
                        // table full: drop the value
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_TR_INIT : ST_IDLE;
                    end else begin
                        lo_next = '0;
                        hi_next = tail_cnt_reg;
                        if (tail_cnt_reg == '0) begin
                            state_next = ST_WRITE;
                        end else begin
                            mid_next   = tail_cnt_reg[CNT_W-1:1];
                            tail_raddr = tail_cnt_reg[CNT_W-1:1];
                            tail_re    = 1'b1;
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (srch_lo < srch_hi) begin
                    mid_next   = srch_mid[IDX_W-1:0];
                    tail_raddr = srch_mid[IDX_W-1:0];
                    tail_re    = 1'b1;
                end else begin
                    // fetch the holder of the tail one shorter
                    src_raddr  = IDX_W'(srch_lo - CNT_W'(1));
                    src_re     = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (lo_reg == tail_cnt_reg) begin
                    tail_cnt_next = tail_cnt_reg + CNT_W'(1);
                end
                item_cnt_next = item_cnt_reg + CNT_W'(1);
                state_next    = final_reg ? ST_TR_INIT : ST_IDLE;
            end
            ST_TR_INIT: begin
                src_raddr  = last_slot[IDX_W-1:0];
                src_re     = 1'b1;
                slot_next  = last_slot[IDX_W-1:0];
                state_next = ST_TR_CUR;
            end
            ST_TR_CUR: begin
                cur_next   = src_q;
                state_next = ST_TR_RD;
            end
            ST_TR_RD: begin
                state_next = ST_TR_WR;
            end
            ST_TR_WR: begin
                cur_next = pred_q[IDX_W-1:0];
                if (slot_reg == '0) begin
                    state_next = ST_EM_RD;
                end else begin
                    slot_next  = slot_reg - IDX_W'(1);
                    state_next = ST_TR_RD;
                end
            end
            ST_EM_RD: begin
                state_next = ST_EM_LD;
            end
            ST_EM_LD: begin
                out_ld.load = 1'b1;
                state_next  = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (taken) begin
                    if (at_last) begin
                        tail_cnt_next = '0;
                        item_cnt_next = '0;
                        ovf_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        slot_next  = slot_reg + IDX_W'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tail_cnt_reg <= '0;
            item_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tail_cnt_reg <= tail_cnt_next;
            item_cnt_reg <= item_cnt_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        slot_reg <= slot_next;
        cur_reg  <= cur_next;
        if (s_accept) begin
            value_reg <= s_tdata;
            final_reg <= s_tlast;
        end
    end

    // tail values: search reads, update writes
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            tail_mem[pos] <= value_reg;
        end
        if (tail_re) begin
            tail_q <= tail_mem[tail_raddr];
        end
    end

    // tail holders
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            src_mem[pos] <= idx;
        end
        if (src_re) begin
            src_q <= src_mem[src_raddr];
        end
    end

    // predecessor links and stored values, read during the trace
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            pred_mem[idx] <= pred_val;
        end
        if (state_reg == ST_TR_RD) begin
            pred_q <= pred_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            stored_mem[idx] <= value_reg;
        end
        if (state_reg == ST_TR_RD) begin
            stored_q <= stored_mem[cur_reg];
        end
    end

    // result buffer: filled back to front, drained front to back
    always_ff @(posedge aclk) begin
        if (state_reg == ST_TR_WR) begin
            buf_mem[slot_reg] <= stored_q;
        end
        if (state_reg == ST_EM_RD) begin
            buf_q <= buf_mem[slot_reg];
        end
    end

    lis_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (out_ld),
        .taken    (taken),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### sv/lis_checker.sv
`include "assert_macros.svh"

module lis_checker
    import lis_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    // whole result word: tdata, tlast, tuser
    logic [M_TDATA_W+1:0] m_word;

    assign m_word = {m_tuser, m_tlast, m_tdata};

    // no result pending right after reset
    `LIS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

    // input side is closed while results stream out
    `LIS_ASSERT(a_one_side, !(s_tready && m_tvalid), "input ready during output")

    // a stalled result holds
    `LIS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_word), "stalled result changed")

    // every result reports a nonempty run
    `LIS_ASSERT(a_len_nz, m_tvalid |-> (m_tdata[M_TDATA_W-2:VALUE_W] != '0), "zero run length")

endmodule

bind lis_with_reconstruction lis_checker u_lis_checker (.*);
